>>> sv/impedance_from_dft_calibrated_unit_defines.svh
// Assertion helpers for the block's module
`ifndef IMPEDANCE_FROM_DFT_CALIBRATED_UNIT_DEFINES_SVH
`define IMPEDANCE_FROM_DFT_CALIBRATED_UNIT_DEFINES_SVH

// Same-cycle implication, held off during reset
`define IFDCU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define IFDCU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ifdcu_pkg.sv
package ifdcu_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_EVAL,
        ST_PREP,
        ST_DIV,
        ST_ROT,
        ST_SCALE,
        ST_DONE
    } t_state;

    localparam logic       OP_CAL   = 1'b0;
    localparam logic       OP_MEAS  = 1'b1;
    localparam logic [1:0] STAT_OK  = 2'd0;
    localparam logic [1:0] STAT_SAT = 2'd1;
    localparam logic [1:0] STAT_BAD = 2'd2;

    localparam logic [1:0]  ADDR_CAL_OHMS  = 2'd0;
    localparam logic [23:0] CAL_OHMS_RESET = 24'd220000;
    localparam int          ROOT_STEPS     = 24;
    localparam int          DIV_STEPS      = 40;
    localparam int          CORDIC_STEPS   = 16;
    localparam int          SCALE_STEPS    = 5;
    localparam logic [32:0] CORDIC_INV_GAIN = 33'sd652032874;
    localparam logic [39:0] MAG_MAX        = 40'hFF_FFFF_FFFF;

    // Arctangent of 2^-i, pi = 2^31
    function automatic logic [29:0] atan_lut(input logic [3:0] idx);
        logic [29:0] v;
        case (idx)
            4'd0:    v = 30'd536870912;
            4'd1:    v = 30'd316933406;
            4'd2:    v = 30'd167458907;
            4'd3:    v = 30'd85004756;
            4'd4:    v = 30'd42667331;
            4'd5:    v = 30'd21354465;
            4'd6:    v = 30'd10679838;
            4'd7:    v = 30'd5340245;
            4'd8:    v = 30'd2670163;
            4'd9:    v = 30'd1335087;
            4'd10:   v = 30'd667544;
            4'd11:   v = 30'd333772;
            4'd12:   v = 30'd166886;
            4'd13:   v = 30'd83443;
            4'd14:   v = 30'd41722;
            4'd15:   v = 30'd20861;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/impedance_from_dft_calibrated_unit.sv
// Impedance from calibrated DFT results.
// Input stream: one beat per DFT point; tuser carries the opcode (calibrate or
// measure), tdata the signed real and imaginary parts. Output stream: one beat
// per input beat with raw magnitude, phase, |Z|, resistance, reactance, status.
// Configuration: APB register at address 0 holds the calibration resistor in
// ohms; write it only while the block is idle.
// One item is in flight at a time; tready is high only when idle, so a new
// beat is taken only once the previous item has finished.
// Steps: a measure runs 24 square-root steps with the vectoring CORDIC
// alongside, then 40 divider steps, 16 rotation CORDIC steps and 5
// partial-product steps; a saturated measure skips the divider; calibrate,
// zero magnitude and uncalibrated measure end after the square root.
// The square root and divider are bit-serial.
// A finished result sits in the output register; the next item is taken as
// soon as that result has been passed on or parked there. If the receiver
// stalls, the block holds the next result until the register frees.
// Reset clears the calibration (status 2 on measure until calibrated) and
// restores the resistor value to 220000 ohms.
`include "impedance_from_dft_calibrated_unit_defines.svh"
module impedance_from_dft_calibrated_unit
    import ifdcu_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [31:0]  i_s_axis_tdata,  // re[15:0], im[31:16]
    input  logic         i_s_axis_tuser,  // opcode[0]
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // raw_magnitude[23:0], phase_angle[39:24], impedance_magnitude[79:40],
    // resistance[120:80], reactance[161:121], status[163:162], zero pad
    output logic [167:0] o_m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    t_state r_state, n_state;
    logic [5:0]  r_cnt;
    logic        r_op;
    logic        r_zvec;
    logic [23:0] r_ohms;
    logic [23:0] r_cal_mag;
    logic [15:0] r_sys;
    // square root
    logic [47:0] r_rad;
    logic [24:0] r_srem;
    logic [23:0] r_root;
    // vectoring CORDIC
    logic signed [27:0] r_vx, r_vy;
    logic signed [33:0] r_vz;
    // divider
    logic [56:0] r_dvd;
    logic [24:0] r_rem;
    // rotation CORDIC
    logic signed [32:0] r_rx, r_ry, r_rz;
    // scaling
    logic [62:0] r_acc;
    // result
    logic [23:0] r_mag;
    logic [15:0] r_ph;
    logic [39:0] r_zmag;
    logic signed [40:0] r_res, r_rea;
    logic [1:0]  r_status;
    logic        r_ov;
    logic [167:0] r_odata;

    logic accept, out_free, cfg_wr;
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_ov || i_m_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_odata;
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_CAL_OHMS) ? {8'd0, r_ohms} : 32'd0;

    // Input conditioning: squares and pre-rotation
    logic signed [15:0] in_re, in_im;
    logic [31:0] in_sq;
    logic signed [27:0] in_x, in_y;
    assign in_re = i_s_axis_tdata[15:0];
    assign in_im = i_s_axis_tdata[31:16];
    assign in_sq = 32'(unsigned'(32'(in_re * in_re))) + 32'(unsigned'(32'(in_im * in_im)));
    assign in_x  = 28'(in_re) <<< 8;
    assign in_y  = 28'(in_im) <<< 8;

    // Square-root step: two radicand bits a cycle
    logic [26:0] sq_t, sq_trial;
    logic        sq_ge;
    assign sq_t     = {r_srem, r_rad[47:46]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = sq_t >= sq_trial;

    // Vectoring CORDIC step
    logic signed [27:0] v_xs, v_ys;
    logic signed [33:0] v_at;
    assign v_xs = r_vx >>> r_cnt[3:0];
    assign v_ys = r_vy >>> r_cnt[3:0];
    assign v_at = 34'(atan_lut(r_cnt[3:0]));

    // Angle and phase
    logic [33:0] vz_rnd;
    logic [15:0] ang, ph_meas;
    assign vz_rnd  = r_vz + 34'sd32768;
    assign ang     = r_zvec ? 16'd0 : vz_rnd[31:16];
    assign ph_meas = ang - r_sys;

    // Divider step: one quotient bit a cycle
    logic [24:0] d_t;
    logic        d_ge, d_sat;
    assign d_t   = {r_rem[23:0], r_dvd[39]};
    assign d_ge  = d_t >= {1'b0, r_mag};
    assign d_sat = {7'd0, r_dvd[56:40]} >= r_mag;

    // Rotation CORDIC step
    logic signed [32:0] r_xs, r_ys, r_at;
    assign r_xs = r_rx >>> r_cnt[3:0];
    assign r_ys = r_ry >>> r_cnt[3:0];
    assign r_at = 33'(atan_lut(r_cnt[3:0]));

    // Round, clamp and map cosine and sine by quadrant
    logic signed [32:0] cx_r, sy_r;
    logic signed [24:0] cx_s, sy_s;
    logic signed [23:0] cc, ss, cos_v, sin_v, fac;
    assign cx_r = r_rx + 33'sd128;
    assign sy_r = r_ry + 33'sd128;
    assign cx_s = cx_r[32:8];
    assign sy_s = sy_r[32:8];
    always_comb begin
        cc = (cx_s > 25'sd4194304) ? 24'sd4194304 :
             (cx_s < -25'sd4194304) ? -24'sd4194304 : cx_s[23:0];
        ss = (sy_s > 25'sd4194304) ? 24'sd4194304 :
             (sy_s < -25'sd4194304) ? -24'sd4194304 : sy_s[23:0];
        case (r_ph[15:14])
            2'd0:    begin cos_v = cc;  sin_v = ss;  end
            2'd1:    begin cos_v = -ss; sin_v = cc;  end
            2'd2:    begin cos_v = -cc; sin_v = -ss; end
            default: begin cos_v = ss;  sin_v = -cc; end
        endcase
    end

    // Partial products: low then high half of |Z|, cosine then sine
    logic [22:0] fac_abs;
    logic [19:0] z_half;
    logic [42:0] pp;
    logic [62:0] acc_rnd;
    logic [40:0] scaled;
    logic        prev_neg;
    assign fac      = (r_cnt >= 6'd2) ? sin_v : cos_v;
    assign fac_abs  = fac[23] ? 23'(-fac) : fac[22:0];
    assign z_half   = (r_cnt == 6'd1 || r_cnt == 6'd3) ? r_zmag[39:20] : r_zmag[19:0];
    assign pp       = 43'(z_half) * 43'(fac_abs);
    assign acc_rnd  = r_acc + 63'd2097152;
    assign scaled   = acc_rnd[62:22];
    assign prev_neg = (r_cnt == 6'd2) ? cos_v[23] : sin_v[23];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (accept) n_state = ST_ROOT;
            ST_ROOT:  if (r_cnt == 6'(ROOT_STEPS - 1)) n_state = ST_EVAL;
            ST_EVAL: begin
                if (r_op == OP_CAL || r_root == 24'd0 || r_cal_mag == 24'd0)
                    n_state = ST_DONE;
                else
                    n_state = ST_PREP;
            end
            ST_PREP:  n_state = d_sat ? ST_ROT : ST_DIV;
            ST_DIV:   if (r_cnt == 6'(DIV_STEPS - 1)) n_state = ST_ROT;
            ST_ROT:   if (r_cnt == 6'(CORDIC_STEPS - 1)) n_state = ST_SCALE;
            ST_SCALE: if (r_cnt == 6'(SCALE_STEPS - 1)) n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_ov      <= 1'b0;
            r_ohms    <= CAL_OHMS_RESET;
            r_cal_mag <= '0;
            r_sys     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (n_state != r_state) ? 6'd0 : r_cnt + 6'd1;
            if (cfg_wr) r_ohms <= pwdata[23:0];
            // update calibration at the end of a calibrate item
            if (r_state == ST_EVAL && r_op == OP_CAL) begin
                r_cal_mag <= r_root;
                r_sys     <= ang;
            end
            // hold result until taken
            if (r_state == ST_DONE && out_free) r_ov <= 1'b1;
            else if (i_m_axis_tready) r_ov <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_op   <= i_s_axis_tuser;
                r_zvec <= (in_re == 16'sd0) && (in_im == 16'sd0);
                r_rad  <= {in_sq, 16'd0};
                r_srem <= '0;
                r_root <= '0;
                if (in_re < 0) begin
                    if (in_im >= 0) begin
                        r_vx <= in_y; r_vy <= -in_x; r_vz <= 34'sd1073741824;
                    end else begin
                        r_vx <= -in_y; r_vy <= in_x; r_vz <= -34'sd1073741824;
                    end
                end else begin
                    r_vx <= in_x; r_vy <= in_y; r_vz <= '0;
                end
            end
            ST_ROOT: begin
                r_rad  <= r_rad << 2;
                r_srem <= sq_ge ? 25'(sq_t - sq_trial) : sq_t[24:0];
                r_root <= {r_root[22:0], sq_ge};
                if (r_cnt < 6'(CORDIC_STEPS)) begin
                    if (r_vy > 0) begin
                        r_vx <= r_vx + v_ys; r_vy <= r_vy - v_xs; r_vz <= r_vz + v_at;
                    end else begin
                        r_vx <= r_vx - v_ys; r_vy <= r_vy + v_xs; r_vz <= r_vz - v_at;
                    end
                end
            end
            ST_EVAL: begin
                r_mag  <= r_root;
                r_zmag <= '0;
                r_res  <= '0;
                r_rea  <= '0;
                r_dvd  <= 57'({48'(r_ohms) * 48'(r_cal_mag), 8'd0}) + 57'(r_root[23:1]);
                r_rx   <= CORDIC_INV_GAIN;
                r_ry   <= '0;
                r_rz   <= 33'({ph_meas[13:0], 16'd0});
                if (r_op == OP_CAL) begin
                    r_ph     <= ang;
                    r_status <= (r_root == 24'd0) ? STAT_BAD : STAT_OK;
                end else begin
                    r_ph     <= ph_meas;
                    r_status <= (r_root == 24'd0 || r_cal_mag == 24'd0) ? STAT_BAD : STAT_OK;
                end
            end
            ST_PREP: begin
                r_rem <= {8'd0, r_dvd[56:40]};
                if (d_sat) begin
                    r_zmag   <= MAG_MAX;
                    r_status <= STAT_SAT;
                end
            end
            ST_DIV: begin
                r_rem  <= d_ge ? 25'(d_t - {1'b0, r_mag}) : d_t;
                r_dvd  <= r_dvd << 1;
                r_zmag <= {r_zmag[38:0], d_ge};
            end
            ST_ROT: begin
                if (r_rz >= 0) begin
                    r_rx <= r_rx - r_ys; r_ry <= r_ry + r_xs; r_rz <= r_rz - r_at;
                end else begin
                    r_rx <= r_rx + r_ys; r_ry <= r_ry - r_xs; r_rz <= r_rz + r_at;
                end
            end
            ST_SCALE: begin
                if (r_cnt == 6'd1 || r_cnt == 6'd3)
                    r_acc <= r_acc + (63'(pp) << 20);
                else
                    r_acc <= 63'(pp);
                if (r_cnt == 6'd2)
                    r_res <= prev_neg ? -signed'(scaled) : signed'(scaled);
                if (r_cnt == 6'd4)
                    r_rea <= prev_neg ? -signed'(scaled) : signed'(scaled);
            end
            ST_DONE: begin
                if (out_free)
                    r_odata <= {4'd0, r_status, r_rea, r_res, r_zmag, r_ph, r_mag};
            end
            default: ;
        endcase
    end

    `IFDCU_ASSERT_NXT(a_accept_starts, accept, r_state == ST_ROOT, "accept did not start root")
    `IFDCU_ASSERT_IMP(a_div_bound, r_state == ST_DIV, r_cnt < 6'(DIV_STEPS), "divider overran")
    `IFDCU_ASSERT_IMP(a_status_code, r_ov, o_m_axis_tdata[163:162] != 2'd3, "bad status code")
    `IFDCU_ASSERT_NXT(a_done_emits, r_state == ST_DONE && out_free, r_ov && r_state == ST_IDLE,
        "result not emitted")

endmodule

>>> tb/sv/impedance_from_dft_calibrated_unit_tb.sv
module impedance_from_dft_calibrated_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ifdcu_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM       = 830;

    typedef struct packed {
        logic        opcode;
        logic [15:0] re;
        logic [15:0] im;
    } t_point;

    typedef struct packed {
        logic [1:0]  status;
        logic [40:0] reactance;
        logic [40:0] resistance;
        logic [39:0] zmag;
        logic [15:0] phase;
        logic [23:0] rawmag;
    } t_reading;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;   // re[15:0], im[31:16]
    logic         s_tuser;   // opcode[0]
    logic         m_tvalid;
    logic         m_tready;
    logic [167:0] m_tdata;   // rawmag, phase, |Z|, R, X, status, pad
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [1:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    impedance_from_dft_calibrated_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Predictor state
    logic [23:0] ohms_model;
    logic [23:0] calmag_model;
    logic [15:0] sysphase_model;

    t_point   point_q[$];
    t_reading reading_q[$];
    int  errors;
    int  accepted_in;
    int  idle_cycles;
    int  send_gap;
    int  recv_gap;
    int  hold_off;
    bit  stim_done;

    localparam longint ATAN_Q31[16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [23:0] root_q8(longint re, longint im);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = (re * re + im * im) << 16;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[23:0];
    endfunction

    function automatic logic [15:0] bam_angle(longint re, longint im);
        longint x, y, z, t, xs, ys;
        if (re == 0 && im == 0) return 16'd0;
        x = re * 256;
        y = im * 256;
        z = 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = 64'sd1 << 30;
            end else begin
                x = -y; y = t; z = -(64'sd1 << 30);
            end
        end
        for (int i = 0; i < 16; i++) begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (y > 0) begin
                x = x + ys; y = y - xs; z = z + ATAN_Q31[i];
            end else begin
                x = x - ys; y = y + xs; z = z - ATAN_Q31[i];
            end
        end
        t = fshift(z + 32768, 16);
        return t[15:0];
    endfunction

    function automatic longint unit_clamp(longint v);
        v = fshift(v + 128, 8);
        if (v > 4194304) return 4194304;
        if (v < -4194304) return -4194304;
        return v;
    endfunction

    function automatic longint scaled(longint zm, longint f);
        longint a, r;
        a = (f < 0) ? -f : f;
        r = (zm * a + (64'sd1 << 21)) >>> 22;
        return (f < 0) ? -r : r;
    endfunction

    // Work out the reading for one point and update the calibration on a calibrate point
    function automatic t_reading predict_reading(t_point p);
        t_reading    rd;
        longint      re, im, x, y, z, xs, ys, cc, ss, c, s;
        logic [15:0] ang;
        logic [63:0] num;
        logic [63:0] q;
        re = longint'($signed(p.re));
        im = longint'($signed(p.im));
        rd = '0;
        rd.rawmag = root_q8(re, im);
        ang = bam_angle(re, im);
        if (p.opcode == OP_CAL) begin
            calmag_model   = rd.rawmag;
            sysphase_model = ang;
            rd.phase = ang;
            if (rd.rawmag == 0) rd.status = STAT_BAD;
        end else begin
            rd.phase = ang - sysphase_model;
            if (rd.rawmag == 0 || calmag_model == 0) begin
                rd.status = STAT_BAD;
            end else begin
                num = 64'(ohms_model) * 64'(calmag_model) * 64'd256;
                q = (num + 64'(rd.rawmag >> 1)) / 64'(rd.rawmag);
                if (q > 64'(MAG_MAX)) begin
                    q = 64'(MAG_MAX);
                    rd.status = STAT_SAT;
                end
                rd.zmag = q[39:0];
                x = 652032874;
                y = 0;
                z = longint'(rd.phase[13:0]) * 65536;
                for (int i = 0; i < 16; i++) begin
                    xs = fshift(x, i);
                    ys = fshift(y, i);
                    if (z >= 0) begin
                        x = x - ys; y = y + xs; z = z - ATAN_Q31[i];
                    end else begin
                        x = x + ys; y = y - xs; z = z + ATAN_Q31[i];
                    end
                end
                cc = unit_clamp(x);
                ss = unit_clamp(y);
                case (rd.phase[15:14])
                    2'd0:    begin c = cc;  s = ss;  end
                    2'd1:    begin c = -ss; s = cc;  end
                    2'd2:    begin c = -cc; s = -ss; end
                    default: begin c = ss;  s = -cc; end
                endcase
                rd.resistance = 41'(scaled(longint'(q), c));
                rd.reactance  = 41'(scaled(longint'(q), s));
            end
        end
        return rd;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Input driver: take points from the queue with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (s_tvalid && s_tready) begin
            accepted_in <= accepted_in + 1;
            reading_q.push_back(predict_reading(point_q.pop_front()));
            if (point_q.size() != 0 && send_gap == 0 && $urandom_range(0, 3) == 0) begin
                s_tdata <= {point_q[0].im, point_q[0].re};
                s_tuser <= point_q[0].opcode;
            end else begin
                s_tvalid <= 1'b0;
                send_gap <= $urandom_range(0, 15);
            end
        end else if (!s_tvalid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (point_q.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {point_q[0].im, point_q[0].re};
                s_tuser  <= point_q[0].opcode;
            end
        end
    end

    // Output monitor with random stalls and long hold-offs while the input count stands at 300
    always @(posedge i_clk) begin
        t_reading got, want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = t_reading'(m_tdata[163:0]);
                if (reading_q.size() == 0) begin
                    $display("%0t: unexpected beat %h", $time, got);
                    errors <= errors + 1;
                end else begin
                    want = reading_q.pop_front();
                    if (got.rawmag !== want.rawmag)
                        $display("%0t: rawmag exp %h got %h", $time, want.rawmag, got.rawmag);
                    if (got.phase !== want.phase)
                        $display("%0t: phase exp %h got %h", $time, want.phase, got.phase);
                    if (got.zmag !== want.zmag)
                        $display("%0t: zmag exp %h got %h", $time, want.zmag, got.zmag);
                    if (got.resistance !== want.resistance)
                        $display("%0t: resistance exp %h got %h", $time,
                                 want.resistance, got.resistance);
                    if (got.reactance !== want.reactance)
                        $display("%0t: reactance exp %h got %h", $time,
                                 want.reactance, got.reactance);
                    if (got.status !== want.status)
                        $display("%0t: status exp %h got %h", $time, want.status, got.status);
                    if (got !== want) errors <= errors + 1;
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_tready <= 1'b0;
            end else if (accepted_in == 300 && recv_gap == 0 && m_tready) begin
                hold_off <= 600;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else if (m_tready && m_tvalid) begin
                m_tready <= 1'b0;
                recv_gap <= $urandom_range(0, 15);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on handshake progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            idle_cycles <= 0;
        end else if (!(stim_done && point_q.size() == 0 && reading_q.size() == 0)) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic add_point(logic op, logic [15:0] re, logic [15:0] im);
        t_point p;
        p.opcode = op;
        p.re = re;
        p.im = im;
        point_q.push_back(p);
    endtask

    task automatic drain;
        while (point_q.size() != 0 || reading_q.size() != 0 || s_tvalid)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_ohms(logic [23:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CAL_OHMS;
        pwdata  <= {8'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ohms_model = v;
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 4)) - 16'd2;
            1:       return 16'($urandom_range(0, 255)) - 16'd128;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [23:0] ohms_set[4];
        errors = 0;
        accepted_in = 0;
        hold_off = 0;
        stim_done = 1'b0;
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        ohms_model = CAL_OHMS_RESET;
        calmag_model = '0;
        sysphase_model = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: uncalibrated measure, zero vectors, extremes, saturation
        add_point(OP_MEAS, 16'd1000, 16'd500);
        add_point(OP_CAL, 16'd0, 16'd0);
        add_point(OP_MEAS, 16'd300, 16'hFF00);
        add_point(OP_CAL, 16'd20000, 16'd3000);
        add_point(OP_MEAS, 16'd0, 16'd0);
        add_point(OP_MEAS, 16'h8000, 16'h8000);
        add_point(OP_MEAS, 16'h7FFF, 16'h7FFF);
        add_point(OP_MEAS, 16'h8000, 16'd0);
        add_point(OP_MEAS, 16'd0, 16'h7FFF);
        add_point(OP_MEAS, 16'd0, 16'h8000);
        add_point(OP_MEAS, 16'hFFFF, 16'd1);
        add_point(OP_MEAS, 16'hFFFF, 16'hFFFF);
        add_point(OP_MEAS, 16'd1, 16'd0);
        add_point(OP_CAL, 16'h8000, 16'h8000);
        add_point(OP_MEAS, 16'd1, 16'd0);
        add_point(OP_MEAS, 16'h1234, 16'hABCD);
        add_point(OP_CAL, 16'hC000, 16'h4000);
        add_point(OP_MEAS, 16'h4000, 16'hC000);
        drain();

        // Register extremes, including zero, then random phases
        ohms_set = '{24'hFFFFFF, 24'd1, 24'd0, 24'd220000};
        for (int ph = 0; ph < 5; ph++) begin
            if (ph < 4) write_ohms(ohms_set[ph]);
            else write_ohms(24'($urandom));
            add_point(OP_CAL, 16'd1, 16'd1);
            add_point(OP_MEAS, 16'h7FFF, 16'h8000);
            for (int k = 0; k < N_RANDOM / 5; k++)
                add_point(($urandom_range(0, 7) == 0) ? OP_CAL : OP_MEAS,
                          rand_comp(), rand_comp());
            drain();
        end

        stim_done = 1'b1;
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
